FILE: rtl/dspdc_pkg.sv
// Shared types and constants for the dual-side PID drive controller.
// Holds register index codes, move mode codes and fixed field widths.
// No dependencies.
package dspdc_pkg;

  // APB register map: register i sits at byte address 4*i
  localparam int ADDR_W = 5;
  localparam int APB_DW = 32;

  typedef enum logic [2:0] {
    REG_MOVE_MODE       = 3'd0,
    REG_TARGET_POSITION = 3'd1,
    REG_REVERSE         = 3'd2,
    REG_SWING_SIDE_LEFT = 3'd3,
    REG_GAIN_P          = 3'd4,
    REG_GAIN_I          = 3'd5,
    REG_GAIN_D          = 3'd6,
    REG_TOLERANCE       = 3'd7
  } reg_idx_t;

  // Move modes; the spare code behaves as straight drive
  typedef enum logic [1:0] {
    MODE_STRAIGHT = 2'd0,
    MODE_POINT    = 2'd1,
    MODE_SWING    = 2'd2
  } move_mode_t;

  localparam int GAIN_W     = 16;
  localparam int TOL_W      = 10;
  localparam int INTEG_W    = 32;
  localparam int DRIVE_W    = 8;
  localparam int DRIVE_MAX  = 127;

  // Reset values of the gain_p and tolerance registers
  localparam logic [GAIN_W-1:0] GAIN_P_RESET = 16'd256;
  localparam logic [TOL_W-1:0]  TOL_RESET    = 10'd50;

endpackage

FILE: rtl/dual_side_pid_drive_controller_unit.sv
// Top level of the dual-side PID drive controller: six-stage datapath,
// APB configuration registers and per-side PID state.
// Depends on dspdc_pkg.
//
// Usage:
//  - Input stream (s_axis_*): one item per sample tick, six encoder positions
//    in tdata and the new_move flag in tuser. new_move clears both integrals
//    and both previous errors before the item is processed.
//  - Output stream (m_axis_*): one result item per input item: left and right
//    drive in tdata, done flag in tuser.
//  - APB port: eight registers at byte addresses 0x00..0x1C; write only while
//    the block holds no items in flight.
//  - Pipeline: the input register loads at the edge that accepts an item,
//    then side sum, divide-by-3 multiply, error and PID state update, gain
//    multiplies, sum and saturate into the output register.
//  - Throughput: one item per cycle unless the output stalls; the PID state
//    loop is a single stage of adds and one saturation, so consecutive
//    samples follow back to back.
//  - Reset: rst (synchronous) empties the pipeline, clears the PID state and
//    loads the register reset values.
//  - Stall: each stage holds only while the next is full and stalled, so
//    bubbles close up; input is taken while a result waits until all fill.
module dual_side_pid_drive_controller_unit #(
  parameter int POSITION_BITS  = 24,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // tdata: left_front_pos, left_mid_pos, left_back_pos,
  //        right_front_pos, right_mid_pos, right_back_pos
  input  logic [((6*POSITION_BITS+7)/8)*8-1:0]  s_axis_tdata,
  // tuser: new_move
  input  logic                                  s_axis_tuser,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: left_drive, right_drive
  output logic [15:0]                           m_axis_tdata,
  // tuser: done_res
  output logic                                  m_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [dspdc_pkg::ADDR_W-1:0]          paddr,
  input  logic [dspdc_pkg::APB_DW-1:0]          pwdata,
  output logic [dspdc_pkg::APB_DW-1:0]          prdata,
  output logic                                  pready
);
  import dspdc_pkg::*;

  localparam int P         = POSITION_BITS;
  localparam int SUMW      = P + 2;              // sum of three encoders
  localparam int MAGW      = P + 1;              // magnitude of that sum
  localparam int DIV_SHIFT = MAGW + 2;
  localparam int KW        = DIV_SHIFT - 1;
  localparam logic [KW-1:0] DIV_K = KW'((64'd1 << DIV_SHIFT) / 3);
  localparam int PRODW     = MAGW + KW;
  localparam int ISW       = ((P + 1 > INTEG_W) ? (P + 1) : INTEG_W) + 1;
  localparam int DW        = P + 2;              // derivative
  localparam int PEW       = P + 1 + GAIN_W + 1;
  localparam int PIW       = INTEG_W + GAIN_W + 1;
  localparam int PDW       = DW + GAIN_W + 1;
  localparam int SMW       = ((PIW > PDW) ? PIW : PDW) + 2;
  localparam int NSTG      = 6;

  localparam logic signed [ISW-1:0] INT_MAX_W = ISW'({1'b0, {(INTEG_W-1){1'b1}}});
  localparam logic signed [ISW-1:0] INT_MIN_W = -INT_MAX_W - ISW'(1);
  localparam logic signed [SMW-1:0] DRV_MAX_W = SMW'(DRIVE_MAX);
  localparam logic signed [SMW-1:0] DRV_MIN_W = -DRV_MAX_W;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [1:0]          move_mode;
  logic signed [P-1:0] target_position;
  logic                reverse;
  logic                swing_side_left;
  logic [GAIN_W-1:0]   gain_p;
  logic [GAIN_W-1:0]   gain_i;
  logic [GAIN_W-1:0]   gain_d;
  logic [TOL_W-1:0]    tolerance;
  reg_idx_t            reg_idx;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_mode       <= MODE_STRAIGHT;
      target_position <= '0;
      reverse         <= 1'b0;
      swing_side_left <= 1'b1;
      gain_p          <= GAIN_P_RESET;
      gain_i          <= '0;
      gain_d          <= '0;
      tolerance       <= TOL_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_MOVE_MODE:       move_mode       <= pwdata[1:0];
        REG_TARGET_POSITION: target_position <= pwdata[P-1:0];
        REG_REVERSE:         reverse         <= pwdata[0];
        REG_SWING_SIDE_LEFT: swing_side_left <= pwdata[0];
        REG_GAIN_P:          gain_p          <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:          gain_i          <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:          gain_d          <= pwdata[GAIN_W-1:0];
        REG_TOLERANCE:       tolerance       <= pwdata[TOL_W-1:0];
      endcase
    end
  end

  // Register readback
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_MOVE_MODE:       prdata = APB_DW'(move_mode);
      REG_TARGET_POSITION: prdata = APB_DW'(target_position);
      REG_REVERSE:         prdata = APB_DW'(reverse);
      REG_SWING_SIDE_LEFT: prdata = APB_DW'(swing_side_left);
      REG_GAIN_P:          prdata = APB_DW'(gain_p);
      REG_GAIN_I:          prdata = APB_DW'(gain_i);
      REG_GAIN_D:          prdata = APB_DW'(gain_d);
      REG_TOLERANCE:       prdata = APB_DW'(tolerance);
    endcase
  end

  // ---------------------------------------------------------------
  // Pipeline flow control: a stage loads when empty or when the next
  // stage loads
  // ---------------------------------------------------------------
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] rdy;

  always_comb begin
    rdy[NSTG-1] = !vld[NSTG-1] || m_axis_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= s_axis_tvalid;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage 0: input register
  // ---------------------------------------------------------------
  logic signed [P-1:0] pos0 [6];
  logic                nm0;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      nm0 <= s_axis_tuser;
      for (int e = 0; e < 6; e++) begin
        pos0[e] <= s_axis_tdata[e*P +: P];
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: per-side encoder sum, split into sign and magnitude
  // ---------------------------------------------------------------
  logic signed [SUMW-1:0] side_sum [2];
  logic [MAGW-1:0]        mag1 [2];
  logic                   sgn1 [2];
  logic signed [P-1:0]    lf1;
  logic                   nm1;

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      side_sum[s] = SUMW'(pos0[3*s]) + SUMW'(pos0[3*s+1]) + SUMW'(pos0[3*s+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      nm1 <= nm0;
      lf1 <= pos0[0];
      for (int s = 0; s < 2; s++) begin
        sgn1[s] <= side_sum[s][SUMW-1];
        mag1[s] <= side_sum[s][SUMW-1] ? MAGW'(-side_sum[s]) : MAGW'(side_sum[s]);
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: divide by 3 as multiply by reciprocal (corrected next stage)
  // ---------------------------------------------------------------
  logic [PRODW-1:0]    prod2 [2];
  logic [MAGW-1:0]     mag2 [2];
  logic                sgn2 [2];
  logic signed [P-1:0] lf2;
  logic                nm2;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      nm2 <= nm1;
      lf2 <= lf1;
      for (int s = 0; s < 2; s++) begin
        prod2[s] <= PRODW'(mag1[s]) * PRODW'(DIV_K);
        mag2[s]  <= mag1[s];
        sgn2[s]  <= sgn1[s];
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: position, error, integral and derivative; PID state update
  // ---------------------------------------------------------------
  logic signed [INTEG_W-1:0] integral [2];
  logic signed [P:0]         last_error [2];

  logic [P-1:0]              quo0 [2];
  logic [P+1:0]              rem  [2];
  logic [P-1:0]              quo  [2];
  logic signed [P:0]         side_pos [2];
  logic signed [P:0]         avg_err [2];
  logic signed [P:0]         swing_err;
  logic signed [P:0]         err [2];
  logic                      act [2];
  logic signed [INTEG_W-1:0] integ_prev [2];
  logic signed [P:0]         last_prev [2];
  logic signed [ISW-1:0]     integ_sum [2];
  logic signed [INTEG_W-1:0] integ_sat [2];
  logic signed [DW-1:0]      deriv [2];
  logic                      swing;
  logic                      done_c;
  logic [P:0]                tol_w;
  logic                      st_load;

  function automatic logic [P:0] mag_of(input logic signed [P:0] x);
    return x[P] ? -x : x;
  endfunction

  assign swing   = (move_mode == MODE_SWING);
  assign tol_w   = (P+1)'(tolerance);
  assign st_load = rdy[3] && vld[2];

  always_comb begin
    swing_err = (P+1)'(target_position) - (P+1)'(lf2);
    for (int s = 0; s < 2; s++) begin
      // quotient estimate is exact or one low
      quo0[s]     = prod2[s][PRODW-1:DIV_SHIFT];
      rem[s]      = (P+2)'(mag2[s]) - ((P+2)'(quo0[s]) + (P+2)'({quo0[s], 1'b0}));
      quo[s]      = (rem[s] >= (P+2)'(3)) ? quo0[s] + P'(1) : quo0[s];
      side_pos[s] = sgn2[s] ? -(P+1)'(quo[s]) : (P+1)'(quo[s]);
      avg_err[s]  = (P+1)'(target_position) - side_pos[s];
      err[s]      = swing ? swing_err : avg_err[s];
      integ_prev[s] = nm2 ? '0 : integral[s];
      last_prev[s]  = nm2 ? '0 : last_error[s];
      integ_sum[s]  = ISW'(integ_prev[s]) + ISW'(err[s]);
      if (integ_sum[s] > INT_MAX_W) begin
        integ_sat[s] = INTEG_W'(INT_MAX_W);
      end else if (integ_sum[s] < INT_MIN_W) begin
        integ_sat[s] = INTEG_W'(INT_MIN_W);
      end else begin
        integ_sat[s] = INTEG_W'(integ_sum[s]);
      end
      deriv[s] = DW'(err[s]) - DW'(last_prev[s]);
    end
    act[0] = !swing || swing_side_left;
    act[1] = !swing || !swing_side_left;
    if (swing) begin
      done_c = mag_of(swing_err) < tol_w;
    end else begin
      done_c = (mag_of(avg_err[0]) < tol_w) && (mag_of(avg_err[1]) < tol_w);
    end
  end

  // PID state: in swing mode the undriven side only clears on new_move
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 2; s++) begin
        integral[s]   <= '0;
        last_error[s] <= '0;
      end
    end else if (st_load) begin
      for (int s = 0; s < 2; s++) begin
        if (act[s]) begin
          integral[s]   <= integ_sat[s];
          last_error[s] <= err[s];
        end else if (nm2) begin
          integral[s]   <= '0;
          last_error[s] <= '0;
        end
      end
    end
  end

  logic signed [P:0]         e3 [2];
  logic signed [INTEG_W-1:0] i3 [2];
  logic signed [DW-1:0]      d3 [2];
  logic                      act3 [2];
  logic                      done3;
  logic                      negr3;
  logic                      rev3;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int s = 0; s < 2; s++) begin
        e3[s]   <= err[s];
        i3[s]   <= integ_sat[s];
        d3[s]   <= deriv[s];
        act3[s] <= act[s];
      end
      done3 <= done_c;
      negr3 <= (move_mode == MODE_POINT);
      rev3  <= reverse;
    end
  end

  // ---------------------------------------------------------------
  // Stage 4: gain multiplies
  // ---------------------------------------------------------------
  logic signed [PEW-1:0] pe4 [2];
  logic signed [PIW-1:0] pi4 [2];
  logic signed [PDW-1:0] pd4 [2];
  logic                  act4 [2];
  logic                  done4;
  logic                  negr4;
  logic                  rev4;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int s = 0; s < 2; s++) begin
        pe4[s]  <= PEW'(e3[s]) * PEW'($signed({1'b0, gain_p}));
        pi4[s]  <= PIW'(i3[s]) * PIW'($signed({1'b0, gain_i}));
        pd4[s]  <= PDW'(d3[s]) * PDW'($signed({1'b0, gain_d}));
        act4[s] <= act3[s];
      end
      done4 <= done3;
      negr4 <= negr3;
      rev4  <= rev3;
    end
  end

  // ---------------------------------------------------------------
  // Stage 5: sum, floor shift, saturate, zero undriven side, apply signs
  // ---------------------------------------------------------------
  logic signed [SMW-1:0]     pid_sum [2];
  logic signed [SMW-1:0]     pid_shr [2];
  logic signed [DRIVE_W-1:0] drv [2];
  logic signed [DRIVE_W-1:0] ld_c;
  logic signed [DRIVE_W-1:0] rd_c;
  logic signed [DRIVE_W-1:0] ld5;
  logic signed [DRIVE_W-1:0] rd5;
  logic                      done5;
  logic                      act5 [2];

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      pid_sum[s] = SMW'(pe4[s]) + SMW'(pi4[s]) + SMW'(pd4[s]);
      pid_shr[s] = pid_sum[s] >>> GAIN_FRAC_BITS;
      if (!act4[s]) begin
        drv[s] = '0;
      end else if (pid_shr[s] > DRV_MAX_W) begin
        drv[s] = DRIVE_W'(DRV_MAX_W);
      end else if (pid_shr[s] < DRV_MIN_W) begin
        drv[s] = DRIVE_W'(DRV_MIN_W);
      end else begin
        drv[s] = DRIVE_W'(pid_shr[s]);
      end
    end
    ld_c = rev4 ? -drv[0] : drv[0];
    rd_c = (rev4 ^ negr4) ? -drv[1] : drv[1];
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      ld5     <= ld_c;
      rd5     <= rd_c;
      done5   <= done4;
      act5[0] <= act4[0];
      act5[1] <= act4[1];
    end
  end

  assign m_axis_tvalid = vld[NSTG-1];
  assign m_axis_tdata  = {rd5, ld5};
  assign m_axis_tuser  = done5;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_empty_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_undriven_left_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !act5[0]) |-> (m_axis_tdata[7:0] == 8'h00))
    else $error("undriven left side has nonzero drive");

  a_undriven_right_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !act5[1]) |-> (m_axis_tdata[15:8] == 8'h00))
    else $error("undriven right side has nonzero drive");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7:0] != 8'h80 && m_axis_tdata[15:8] != 8'h80))
    else $error("drive outside saturation range");

endmodule
